// ===== hw/rtl/rank_assigner_top_defines.svh =====
// Assertion macros used by the checker file of the rank assigner.
`ifndef RANK_ASSIGNER_TOP_DEFINES_SVH
`define RANK_ASSIGNER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rnkasg_pkg.sv =====
package rnkasg_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 7;
    localparam int POS_W     = 6;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 16;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WAIT,
        ST_DRAIN
    } ra_state_t;

    // Signals that reach every cell alike.
    typedef struct packed {
        logic                    store;
        logic signed [VAL_W-1:0] value;
        logic                    shift;
        logic [CNT_W-1:0]        add_val;
    } cell_bcast_t;

    // Signals decoded for one cell.
    typedef struct packed {
        logic occupied;
        logic write_sel;
        logic add_sel;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/rnkasg_cell.sv =====
module rnkasg_cell
    import rnkasg_pkg::*;
(
    input  logic             clk,
    input  cell_bcast_t      bcast,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] count_in,
    output logic             le,
    output logic [CNT_W-1:0] count_out
);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    gt;
    logic [CNT_W-1:0]        base;
    logic [CNT_W-1:0]        inc;
    logic [CNT_W-1:0]        add;

    assign gt = val_reg > bcast.value;
    assign le = ctrl.occupied & ~gt;

    always_comb
    begin
        base = (bcast.store && ctrl.write_sel) ? '0 : count_reg;
        inc  = (bcast.store && ctrl.occupied && gt) ? CNT_W'(1) : '0;
        add  = ctrl.add_sel ? bcast.add_val : '0;
        if (bcast.shift)
        begin
            count_next = count_in;
        end
        else
        begin
            count_next = base + inc + add;
        end
        val_next = (bcast.store && ctrl.write_sel) ? bcast.value : val_reg;
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        count_reg <= count_next;
    end

    assign count_out = count_reg;

endmodule

// ===== hw/rtl/rank_assigner_top.sv =====
// Loading takes one stored word per cycle. After the word marked last is taken, the block
// passes through ST_WAIT and offers the first result in ST_DRAIN; results then follow one
// per cycle while m_tready is high, N results in all. The result drain shifts the
// cell chain one place per result, and no word is taken while results drain.
// Reset: rst_n is asynchronous and active low; it clears the state, fill count and flags.
module rank_assigner_top
    import rnkasg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // [31:0] value (signed)
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // [5:0] position, [12:6] rank, [15:13] zero
    output logic             m_tlast,
    output logic             m_tuser    // [0] overflow
);

    // Each cell holds one stored number and its running count of numbers that rank
    // below it. A new number is compared against every occupied cell in the cycle it
    // arrives: larger cells raise their count at once. The compare results are
    // registered and summed in the following cycle, and that sum becomes the count of
    // the freshly written cell. When the set ends, the ST_WAIT state lets the last
    // sum land, then the counts shift toward cell 0, which feeds the output.

    ra_state_t        state_reg;
    ra_state_t        state_next;
    logic [CNT_W-1:0] item_cnt_reg;
    logic [CNT_W-1:0] item_cnt_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             pend_reg;
    logic             pend_next;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [IDX_W-1:0] pend_idx_next;
    logic [MAX_ITEMS-1:0] le_reg;

    logic [MAX_ITEMS-1:0] le_vec;
    logic [CNT_W-1:0]     chain [MAX_ITEMS+1];
    cell_bcast_t          bcast;
    logic                 in_acc;
    logic                 out_acc;
    logic                 store;
    logic                 is_final;

    assign in_acc   = s_tvalid & s_tready;
    assign out_acc  = m_tvalid & m_tready;
    assign store    = in_acc && (item_cnt_reg < CNT_W'(MAX_ITEMS));
    assign is_final = ({1'b0, pos_reg} + CNT_W'(1)) == item_cnt_reg;

    always_comb
    begin
        bcast.store   = store;
        bcast.value   = s_tdata[VAL_W-1:0];
        bcast.shift   = out_acc;
        bcast.add_val = CNT_W'($countones(le_reg));
    end

    assign chain[MAX_ITEMS] = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_ITEMS; k++)
        begin : g_cell
            cell_ctrl_t ctrl;

            always_comb
            begin
                ctrl.occupied  = CNT_W'(k) < item_cnt_reg;
                ctrl.write_sel = item_cnt_reg[IDX_W-1:0] == IDX_W'(k);
                ctrl.add_sel   = pend_reg && (pend_idx_reg == IDX_W'(k));
            end

            rnkasg_cell u_cell (
                .clk       (clk),
                .bcast     (bcast),
                .ctrl      (ctrl),
                .count_in  (chain[k+1]),
                .le        (le_vec[k]),
                .count_out (chain[k])
            );
        end
    endgenerate

    // Control state machine: load words, let the last sum settle, then drain.
    always_comb
    begin
        state_next    = state_reg;
        item_cnt_next = item_cnt_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (store)
                begin
                    item_cnt_next = item_cnt_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = item_cnt_reg[IDX_W-1:0];
                end
                else if (in_acc)
                begin
                    ovf_next = 1'b1;
                end
                if (in_acc && s_tlast)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_DRAIN;
                pos_next   = '0;
            end
            ST_DRAIN:
            begin
                m_tvalid = 1'b1;
                if (out_acc)
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (is_final)
                    begin
                        state_next    = ST_LOAD;
                        item_cnt_next = '0;
                        ovf_next      = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            item_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            item_cnt_reg <= item_cnt_next;
            ovf_reg      <= ovf_next;
            pos_reg      <= pos_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
        end
    end

    // Compare results of the newest word, summed in the following cycle.
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            le_reg <= le_vec;
        end
    end

    // Cell 0 holds the count for the position being reported.
    assign m_tdata = {{(OUT_W - POS_W - CNT_W){1'b0}}, chain[0] + CNT_W'(1), pos_reg};
    assign m_tlast = is_final;
    assign m_tuser = ovf_reg;

endmodule

// ===== hw/rtl/rnkasg_chk.sv =====
`include "rank_assigner_top_defines.svh"

module rnkasg_chk
    import rnkasg_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast,
    input logic             m_tuser
);

    logic out_stall;

    assign out_stall = m_tvalid && !m_tready;

    // Words are never taken while results are being reported.
    `RA_ASSERT_NOW(a_no_load_in_drain, m_tvalid, !s_tready, "input ready during drain")

    // A stalled result keeps its word.
    `RA_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled word changed")

    // A stalled result keeps its flags as well.
    `RA_ASSERT_NEXT(a_flags_hold, out_stall, $stable({m_tlast, m_tuser}), "flags moved")

    // Ranks are one-based.
    `RA_ASSERT_NOW(a_rank_nonzero, m_tvalid, m_tdata[12:6] != 7'd0, "rank of zero reported")

    // The drain ends right after the final result is taken.
    `RA_ASSERT_NEXT(a_drain_ends, m_tvalid && m_tready && m_tlast, !m_tvalid, "result after final")

endmodule

bind rank_assigner_top rnkasg_chk u_rnkasg_chk (.*);

// ===== test/rank_assigner_top_tb.sv =====
module rank_assigner_top_tb;
    import rnkasg_pkg::*;

    // One reported word as the block should produce it.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] rank;
        logic             final_res;
        logic             overflow;
    } rank_word_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             m_tuser;

    // Shadow copy of the set being loaded: the numbers in arrival order and,
    // for each, how many numbers of the set sort ahead of it so far.
    logic signed [VAL_W-1:0] shadow_values [MAX_ITEMS];
    int                      shadow_ahead  [MAX_ITEMS];
    int                      shadow_size;
    bit                      shadow_dropped;

    // Ranks predicted for the last completed sets, oldest first.
    rank_word_t pending_ranks [$];
    int         error_count;

    // Percentages of cycles in which the sender idles or the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;
    // Cycles left in a long receiver hold-off; only the receiver process counts down.
    int hold_off_left;

    rank_assigner_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Rank bookkeeping for one accepted word. A new number counts every stored
    // number that is less than or equal to it as ahead of itself, which breaks
    // ties by position; each stored number that is larger moves back by one.
    // Once the store is full, further numbers are dropped and flag the set.
    task automatic rank_word(input logic signed [VAL_W-1:0] value, input logic is_last);
        int         ahead;
        rank_word_t res;
        if (shadow_size < MAX_ITEMS)
        begin
            ahead = 0;
            for (int k = 0; k < shadow_size; k++)
            begin
                if (shadow_values[k] <= value)
                    ahead++;
                else
                    shadow_ahead[k]++;
            end
            shadow_values[shadow_size] = value;
            shadow_ahead[shadow_size]  = ahead;
            shadow_size++;
        end
        else
        begin
            shadow_dropped = 1'b1;
        end
        if (is_last)
        begin
            // The whole set is reported in input order once the marked word is in.
            for (int k = 0; k < shadow_size; k++)
            begin
                res.position  = POS_W'(k);
                res.rank      = CNT_W'(shadow_ahead[k] + 1);
                res.final_res = (k == shadow_size - 1);
                res.overflow  = shadow_dropped;
                pending_ranks.push_back(res);
            end
            shadow_size    = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    // Monitor on the rising edge: checks each reported word against the oldest
    // prediction, then feeds every accepted input word to the predictor.
    always @(posedge clk)
    begin
        rank_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_ranks.size() == 0)
                begin
                    $display("%0t: unexpected result word position %0d rank %0d",
                             $time, m_tdata[POS_W-1:0], m_tdata[POS_W +: CNT_W]);
                    error_count++;
                end
                else
                begin
                    want = pending_ranks.pop_front();
                    if (m_tdata[POS_W-1:0] !== want.position)
                    begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, m_tdata[POS_W-1:0]);
                        error_count++;
                    end
                    if (m_tdata[POS_W +: CNT_W] !== want.rank)
                    begin
                        $display("%0t: rank at position %0d expected %0d actual %0d",
                                 $time, want.position, want.rank, m_tdata[POS_W +: CNT_W]);
                        error_count++;
                    end
                    if (m_tlast !== want.final_res)
                    begin
                        $display("%0t: final flag at position %0d expected %0b actual %0b",
                                 $time, want.position, want.final_res, m_tlast);
                        error_count++;
                    end
                    if (m_tuser !== want.overflow)
                    begin
                        $display("%0t: overflow at position %0d expected %0b actual %0b",
                                 $time, want.position, want.overflow, m_tuser);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                rank_word(s_tdata, s_tlast);
        end
    end

    // Receiver: stalls at random, or holds off entirely while a long
    // hold-off is running.
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            m_tready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offers one word and returns on the falling edge after it was taken.
    // The valid stays high on return so that back-to-back words see no gap.
    task automatic send_word(input logic [VAL_W-1:0] value, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Stops offering words and waits until every predicted word has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // A mix of full-range numbers, a small pool that gives many ties,
    // and the extremes of the signed range.
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 3))
            0, 1: v = $urandom();
            2:    v = $urandom_range(0, 6) - 3;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_random_set(input int set_len);
        for (int i = 0; i < set_len; i++)
            send_word(pick_value(), i == set_len - 1);
    endtask

    // A set of one number always ranks it first.
    task automatic test_single_word();
        send_word(32'h0000_0000, 1'b1);
        wait_drained();
    endtask

    // Both ends of the signed range together with the numbers around zero.
    task automatic test_extremes();
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        wait_drained();
    endtask

    // Repeated numbers must take consecutive ranks in order of arrival.
    task automatic test_equal_values();
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(-32'sd3, 1'b0);
        send_word(32'd5, 1'b1);
        wait_drained();
    endtask

    task automatic test_sorted_orders();
        for (int i = 0; i < 4; i++)
            send_word(i * 1000 - 1500, i == 3);
        for (int i = 0; i < 4; i++)
            send_word(1500 - i * 1000, i == 3);
        wait_drained();
    endtask

    // A set that exactly fills the store, then a set whose marked word is
    // the first one dropped.
    task automatic test_full_and_overflow();
        send_random_set(MAX_ITEMS);
        wait_drained();
        send_random_set(MAX_ITEMS + 1);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps going,
    // so the block has to stop taking words while its results wait.
    task automatic test_backpressure();
        @(posedge clk);
        hold_off_left = 400;
        @(negedge clk);
        for (int i = 0; i < 3; i++)
            send_random_set(8);
        wait_drained();
    endtask

    // Mostly short sets, some longer ones, and now and then one past capacity.
    task automatic test_random_sets(input int word_budget);
        int sent;
        int pick;
        int set_len;
        sent = 0;
        while (sent < word_budget)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                set_len = $urandom_range(1, 8);
            else if (pick < 18)
                set_len = $urandom_range(9, 40);
            else if (pick < 19)
                set_len = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS);
            else
                set_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            send_random_set(set_len);
            sent += set_len;
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 0;
        error_count    = 0;
        shadow_size    = 0;
        shadow_dropped = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_word();
        test_extremes();
        test_equal_values();
        test_sorted_orders();
        test_full_and_overflow();
        test_backpressure();

        // Random sets under each mix of sender gaps and receiver stalls.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_sets(16);
        send_idle_pct  = 60;
        recv_stall_pct = 0;
        test_random_sets(16);
        send_idle_pct  = 0;
        recv_stall_pct = 60;
        test_random_sets(16);
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        test_random_sets(16);

        // Let any stray word surface before the verdict.
        recv_stall_pct = 0;
        repeat (20) @(posedge clk);
        if (pending_ranks.size() != 0)
        begin
            $display("%0t: %0d predicted result words never arrived",
                     $time, pending_ranks.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
